// ===== rtl/core/ifla_pkg.sv =====
// Package for the identifier free-list allocator: widths, codes, types.
`timescale 1ns / 1ps
package ifla_pkg;

	// Default number of identifiers managed by the free list
	localparam int NUM_IDS_DEF = 4096;

	// Fixed field widths
	localparam int ID_W   = 16;
	localparam int ST_W   = 2;
	localparam int FREE_W = 13;

	// Command codes
	typedef enum logic {
		CMD_ALLOC   = 1'b0,
		CMD_RELEASE = 1'b1
	} cmd_t;

	// Result status codes
	typedef enum logic [ST_W-1:0] {
		ST_OK           = 2'd0,
		ST_NONE_FREE    = 2'd1,
		ST_OUT_OF_RANGE = 2'd2,
		ST_FULL         = 2'd3
	} status_t;

	// Controller states
	typedef enum logic {
		S_IDLE = 1'b0,
		S_EXEC = 1'b1
	} state_t;

	// Controller to datapath commands
	typedef struct packed {
		logic load;    // capture the command and read the head entry
		logic commit;  // resolve the command, update state, load result
	} ctrl_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic out_free;  // result register can take a new result
	} dp_stat_t;

endpackage

// ===== rtl/core/ifla_if.sv =====
// Channel interfaces of the identifier allocator: command, result, config.
`timescale 1ns / 1ps

// Command channel
interface ifla_cmd_if import ifla_pkg::*; ();
	logic            valid;
	logic            ready;
	cmd_t            command;
	logic [ID_W-1:0] id_in;

	modport source (output valid, output command, output id_in, input ready);
	modport sink   (input valid, input command, input id_in, output ready);
endinterface

// Result channel
interface ifla_rsp_if import ifla_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [ID_W-1:0]   id_out;
	status_t           status;
	logic [FREE_W-1:0] free_left;

	modport source (output valid, output id_out, output status, output free_left,
		input ready);
	modport sink   (input valid, input id_out, input status, input free_left,
		output ready);
endinterface

// Configuration write channel (id_base register)
interface ifla_cfg_if import ifla_pkg::*; ();
	logic            valid;
	logic            ready;
	logic [ID_W-1:0] id_base;

	modport source (output valid, output id_base, input ready);
	modport sink   (input valid, input id_base, output ready);
endinterface

// ===== rtl/core/ifla_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module ifla_ram #(
	parameter int WIDTH = 12,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata_q
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

endmodule

// ===== rtl/core/ifla_ctrl.sv =====
// Controller state machine of the identifier allocator.
`timescale 1ns / 1ps
module ifla_ctrl import ifla_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cmd_valid,
	output logic      cmd_ready,
	input  dp_stat_t  dp_stat,
	output ctrl_cmd_t ctrl_cmd
);

	state_t state_q;
	state_t state_d;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and commands
	always_comb begin
		state_d         = state_q;
		cmd_ready       = 1'b0;
		ctrl_cmd.load   = 1'b0;
		ctrl_cmd.commit = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				cmd_ready = 1'b1;
				if (cmd_valid) begin
					ctrl_cmd.load = 1'b1;
					state_d       = S_EXEC;
				end
			end
			S_EXEC: begin
				// wait until the result register has room
				if (dp_stat.out_free) begin
					ctrl_cmd.commit = 1'b1;
					state_d         = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

// ===== rtl/core/ifla_dp.sv =====
// Datapath of the identifier allocator: free list, pointers, count, result.
`timescale 1ns / 1ps
module ifla_dp import ifla_pkg::*; #(
	parameter int NUM_IDS = NUM_IDS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  ctrl_cmd_t         ctrl_cmd,
	output dp_stat_t          dp_stat,
	input  cmd_t              command,
	input  logic [ID_W-1:0]   id_in,
	ifla_cfg_if.sink          cfg,
	ifla_rsp_if.source        rsp
);

	localparam int AW    = $clog2(NUM_IDS);
	localparam int CW    = $clog2(NUM_IDS + 1);
	localparam int RW    = ID_W + 1;
	localparam logic [AW-1:0] LAST_POS = AW'(NUM_IDS - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(NUM_IDS);
	localparam logic [RW-1:0] RANGE_N  = RW'(NUM_IDS);

	// Control state
	logic [AW-1:0]   head_q;
	logic [AW-1:0]   tail_q;
	logic [CW-1:0]   count_q;
	logic            wrap_q;    // every list position has been written once
	logic [ID_W-1:0] base_q;
	logic            out_valid_q;

	// Payload registers
	cmd_t            cmd_q;
	logic [ID_W-1:0] id_in_q;
	logic [ID_W-1:0] out_id_q;
	status_t         out_status_q;
	logic [FREE_W-1:0] out_free_q;

	// Free-list memory signals
	logic            mem_we;
	logic [AW-1:0]   mem_rdata;

	// Command resolution
	logic [ID_W-1:0] rel_off;
	logic            in_range;
	logic            entry_valid;
	logic [AW-1:0]   alloc_off;
	logic            do_alloc;
	logic            do_release;
	status_t         res_status;
	logic [ID_W-1:0] res_id;
	logic [CW-1:0]   count_d;

	ifla_ram #(
		.WIDTH (AW),
		.DEPTH (NUM_IDS)
	) u_free_list (
		.clk     (clk),
		.we      (mem_we),
		.waddr   (tail_q),
		.wdata   (rel_off[AW-1:0]),
		.re      (ctrl_cmd.load),
		.raddr   (head_q),
		.rdata_q (mem_rdata)
	);

	// Positions below the tail (or all, after the first wrap) hold written
	// offsets; the rest still hold their reset offset, equal to the position.
	always_comb begin
		rel_off     = id_in_q - base_q;
		in_range    = (id_in_q >= base_q) && ({1'b0, rel_off} < RANGE_N);
		entry_valid = wrap_q || (head_q < tail_q);
		alloc_off   = entry_valid ? mem_rdata : head_q;
		do_alloc    = 1'b0;
		do_release  = 1'b0;
		res_status  = ST_OK;
		res_id      = '0;
		count_d     = count_q;
		unique case (cmd_q)
			CMD_ALLOC: begin
				if (count_q == '0) begin
					res_status = ST_NONE_FREE;
				end else begin
					do_alloc = 1'b1;
					res_id   = base_q + ID_W'(alloc_off);
					count_d  = count_q - 1'b1;
				end
			end
			CMD_RELEASE: begin
				priority if (!in_range) begin
					res_status = ST_OUT_OF_RANGE;
				end else if (count_q == FULL_CNT) begin
					res_status = ST_FULL;
				end else begin
					do_release = 1'b1;
					count_d    = count_q + 1'b1;
				end
			end
			default: begin
				res_status = ST_OK;
			end
		endcase
		mem_we = ctrl_cmd.commit && do_release;
	end

	assign dp_stat.out_free = !out_valid_q || rsp.ready;
	assign cfg.ready        = 1'b1;

	// Pointers, count, base register and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q      <= '0;
			tail_q      <= '0;
			count_q     <= FULL_CNT;
			wrap_q      <= 1'b0;
			base_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg.valid) begin
				base_q <= cfg.id_base;
			end
			if (ctrl_cmd.commit) begin
				count_q <= count_d;
				if (do_alloc) begin
					head_q <= (head_q == LAST_POS) ? '0 : head_q + 1'b1;
				end
				if (do_release) begin
					tail_q <= (tail_q == LAST_POS) ? '0 : tail_q + 1'b1;
					if (tail_q == LAST_POS) begin
						wrap_q <= 1'b1;
					end
				end
			end
			if (ctrl_cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Command capture and result payload
	always_ff @(posedge clk) begin
		if (ctrl_cmd.load) begin
			cmd_q   <= command;
			id_in_q <= id_in;
		end
		if (ctrl_cmd.commit) begin
			out_id_q     <= res_id;
			out_status_q <= res_status;
			out_free_q   <= FREE_W'(count_d);
		end
	end

	assign rsp.valid     = out_valid_q;
	assign rsp.id_out    = out_id_q;
	assign rsp.status    = out_status_q;
	assign rsp.free_left = out_free_q;

endmodule

// ===== rtl/core/id_free_list_allocator_top.sv =====
// Top level of the identifier free-list allocator.
`timescale 1ns / 1ps
// Hands out identifiers id_base .. id_base+NUM_IDS-1 from a FIFO free list
// and takes them back on release. A command is accepted in S_IDLE, where
// the head entry of the free-list RAM is read, and resolved in S_EXEC,
// which updates head, tail and count and loads the result register; no new
// command is accepted until S_EXEC is done. The result register holds a
// finished result while the next command is accepted; a command waits in
// S_EXEC only if the previous result has not yet been taken.
// After reset the list is full with offsets in order; no clearing pass is
// run, list positions not yet rewritten return their own offset. Released
// identifiers are range checked but double releases are not detected.
// id_base may be written only while no command is in flight.
module id_free_list_allocator_top import ifla_pkg::*; #(
	parameter int NUM_IDS = NUM_IDS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	ifla_cmd_if.sink   cmd,
	ifla_rsp_if.source rsp,
	ifla_cfg_if.sink   cfg
);

	ctrl_cmd_t ctrl_cmd;
	dp_stat_t  dp_stat;
	logic      cmd_ready_w;

	// Controller
	ifla_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd.valid),
		.cmd_ready (cmd_ready_w),
		.dp_stat   (dp_stat),
		.ctrl_cmd  (ctrl_cmd)
	);

	assign cmd.ready = cmd_ready_w;

	// Datapath
	ifla_dp #(
		.NUM_IDS (NUM_IDS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctrl_cmd (ctrl_cmd),
		.dp_stat  (dp_stat),
		.command  (cmd.command),
		.id_in    (cmd.id_in),
		.cfg      (cfg),
		.rsp      (rsp)
	);

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the identifier free-list allocator top level.
module testbench;
	import ifla_pkg::*;

	localparam int NUM_IDS     = NUM_IDS_DEF;
	localparam int CYCLE_LIMIT = 600000;
	localparam int OFF_W       = $clog2(NUM_IDS);

	typedef struct {
		logic [ID_W-1:0]   id_out;
		status_t           status;
		logic [FREE_W-1:0] free_left;
	} reply_t;

	// Free-list shadow: predicts each reply and holds the replies still owed
	class id_pool_model;
		logic [OFF_W-1:0] offsets [NUM_IDS];
		int               head_pos;
		int               tail_pos;
		int               free_count;
		logic [ID_W-1:0]  id_base;
		reply_t           replies_due [$];
		int               mismatches;

		function new();
			for (int i = 0; i < NUM_IDS; i++)
				offsets[i] = OFF_W'(i);
			head_pos = 0;
			tail_pos = 0;
			free_count = NUM_IDS;
			id_base = '0;
			mismatches = 0;
		endfunction

		// Accepted command: advance the shadow list and queue the reply it owes
		function reply_t log_command(cmd_t op, logic [ID_W-1:0] id);
			reply_t r;
			int     rel;
			r.id_out = '0;
			r.status = ST_OK;
			rel = int'(id) - int'(id_base);
			if (op == CMD_ALLOC) begin
				if (free_count == 0) begin
					r.status = ST_NONE_FREE;
				end else begin
					r.id_out = id_base + ID_W'(offsets[head_pos]);
					head_pos = (head_pos + 1) % NUM_IDS;
					free_count--;
				end
			end else begin
				if (rel < 0 || rel >= NUM_IDS) begin
					r.status = ST_OUT_OF_RANGE;
				end else if (free_count >= NUM_IDS) begin
					r.status = ST_FULL;
				end else begin
					offsets[tail_pos] = OFF_W'(rel);
					tail_pos = (tail_pos + 1) % NUM_IDS;
					free_count++;
				end
			end
			r.free_left = FREE_W'(free_count);
			replies_due.push_back(r);
			return r;
		endfunction

		// Reply transfer: compare with the oldest owed reply
		function void check_reply(logic [ID_W-1:0] id_out, status_t status,
			logic [FREE_W-1:0] free_left);
			reply_t e;
			if (replies_due.size() == 0) begin
				$error("unexpected reply: id_out %h status %0d free_left %0d",
					id_out, status, free_left);
				mismatches++;
				return;
			end
			e = replies_due.pop_front();
			if (id_out !== e.id_out) begin
				$error("id_out: expected %h, actual %h", e.id_out, id_out);
				mismatches++;
			end
			if (status !== e.status) begin
				$error("status: expected %0d, actual %0d", e.status, status);
				mismatches++;
			end
			if (free_left !== e.free_left) begin
				$error("free_left: expected %0d, actual %0d", e.free_left, free_left);
				mismatches++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;

	ifla_cmd_if cmd_ch ();
	ifla_rsp_if rsp_ch ();
	ifla_cfg_if cfg_ch ();

	id_free_list_allocator_top uut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_ch),
		.rsp    (rsp_ch),
		.cfg    (cfg_ch)
	);

	id_pool_model     pool;
	logic [OFF_W-1:0] held_offsets [$];
	logic             no_gaps;
	int               cycle_count = 0;

	// 10 ns clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Run limit
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	// Reply side: random backpressure, held low in reset
	always @(negedge clk)
		rsp_ch.ready <= arst_n && (no_gaps || ($urandom_range(0, 99) >= 34));

	// Reply transfers
	always @(posedge clk)
		if (arst_n && rsp_ch.valid && rsp_ch.ready)
			pool.check_reply(rsp_ch.id_out, rsp_ch.status, rsp_ch.free_left);

	// One command transfer; starts and ends at a falling edge
	task automatic send_cmd(cmd_t op, logic [ID_W-1:0] id);
		reply_t r;
		while (!no_gaps && $urandom_range(0, 99) < 34) begin
			cmd_ch.valid <= 1'b0;
			@(negedge clk);
		end
		cmd_ch.valid   <= 1'b1;
		cmd_ch.command <= op;
		cmd_ch.id_in   <= id;
		do @(posedge clk); while (!cmd_ch.ready);
		r = pool.log_command(op, id);
		if (op == CMD_ALLOC && r.status == ST_OK)
			held_offsets.push_back(OFF_W'(r.id_out - pool.id_base));
		@(negedge clk);
	endtask

	// Hold off commands until every owed reply has come back
	task automatic settle();
		cmd_ch.valid <= 1'b0;
		while (pool.replies_due.size() != 0)
			@(posedge clk);
		repeat (4) @(negedge clk);
	endtask

	// id_base write, only with the block idle
	task automatic write_base(logic [ID_W-1:0] value);
		settle();
		cfg_ch.valid   <= 1'b1;
		cfg_ch.id_base <= value;
		do @(posedge clk); while (!cfg_ch.ready);
		pool.id_base = value;
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	function automatic logic [ID_W-1:0] id_of(logic [OFF_W-1:0] off);
		return pool.id_base + ID_W'(off);
	endfunction

	// Mostly alloc / release of held ids, some stray and duplicate releases
	task automatic run_random(int count);
		int               pick;
		int               idx;
		logic [ID_W-1:0]  junk;
		logic [OFF_W-1:0] off;
		for (int i = 0; i < count; i++) begin
			pick = $urandom_range(0, 99);
			junk = ID_W'($urandom);
			if (pick < 45 || (pick < 85 && held_offsets.size() == 0)) begin
				send_cmd(CMD_ALLOC, junk);
			end else if (pick < 85) begin
				idx = $urandom_range(0, held_offsets.size() - 1);
				off = held_offsets[idx];
				held_offsets.delete(idx);
				send_cmd(CMD_RELEASE, id_of(off));
			end else begin
				case ($urandom_range(0, 3))
					0: send_cmd(CMD_RELEASE, junk);
					1: send_cmd(CMD_RELEASE, pool.id_base - 1'b1);
					2: send_cmd(CMD_RELEASE, pool.id_base + ID_W'(NUM_IDS));
					default: begin
						// double release of an id still handed out
						if (held_offsets.size() != 0)
							send_cmd(CMD_RELEASE, id_of(held_offsets[
								$urandom_range(0, held_offsets.size() - 1)]));
						else
							send_cmd(CMD_RELEASE, junk);
					end
				endcase
			end
		end
	endtask

	initial begin
		pool = new();
		no_gaps = 1'b0;
		arst_n = 1'b0;
		cmd_ch.valid = 1'b0;
		cmd_ch.command = CMD_ALLOC;
		cmd_ch.id_in = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.id_base = '0;
		repeat (7) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed, base 0: release into full list, range edges, double release
		send_cmd(CMD_RELEASE, 16'h0000);
		send_cmd(CMD_ALLOC, 16'h0000);
		send_cmd(CMD_ALLOC, 16'h5A5A);
		send_cmd(CMD_ALLOC, 16'hA5A5);
		send_cmd(CMD_RELEASE, 16'h1000);
		send_cmd(CMD_RELEASE, 16'hFFFF);
		send_cmd(CMD_RELEASE, 16'h0001);
		send_cmd(CMD_RELEASE, 16'h0001);
		send_cmd(CMD_ALLOC, 16'hFFFF);
		send_cmd(CMD_RELEASE, 16'h0FFF);
		send_cmd(CMD_RELEASE, 16'h0000);
		send_cmd(CMD_RELEASE, 16'h0002);
		held_offsets.delete();

		// Directed, top base
		write_base(16'hF000);
		send_cmd(CMD_ALLOC, 16'h0000);
		send_cmd(CMD_RELEASE, 16'hEFFF);
		send_cmd(CMD_RELEASE, 16'hFFFF);
		send_cmd(CMD_RELEASE, 16'h0000);
		send_cmd(CMD_ALLOC, 16'h1234);
		send_cmd(CMD_ALLOC, 16'hFEDC);
		send_cmd(CMD_RELEASE, 16'hF000);

		write_base(16'($urandom_range(1, 61439)));
		run_random(900);

		// Give everything back, then overfill
		while (held_offsets.size() != 0)
			send_cmd(CMD_RELEASE, id_of(held_offsets.pop_front()));
		send_cmd(CMD_RELEASE, id_of('0));
		send_cmd(CMD_RELEASE, id_of('1));

		write_base(16'h0000);
		no_gaps = 1'b1;
		run_random(300);
		no_gaps = 1'b0;
		run_random(400);

		write_base(16'($urandom_range(0, 61440)));
		run_random(300);

		settle();
		repeat (20) @(posedge clk);
		if (pool.mismatches == 0 && pool.replies_due.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
